[hw/rtl/rotary_position_embedding_pair_macros.svh]
// assertion macros shared by the rotary position embedding pair rtl
// depends on nothing; users supply clock and reset names in scope
`ifndef ROTARY_POSITION_EMBEDDING_PAIR_MACROS_SVH
`define ROTARY_POSITION_EMBEDDING_PAIR_MACROS_SVH

// same-cycle implication, disabled in reset
`define RPE_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define RPE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/rpe_pkg.sv]
// constants and elaboration-time helpers for the rotary position embedding pair
// no dependencies
package rpe_pkg;

   localparam int unsigned CORDIC_STEPS = 20;
   localparam int unsigned XY_W = 34;
   localparam int unsigned Z_W = 25;
   localparam int unsigned CS_W = 20;

   localparam logic [63:0] LOG2_TENK = 64'd57070290108;
   localparam logic [63:0] INV_TWO_PI_Q32 = 64'd683565276;
   localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;

   typedef logic signed [Z_W-1:0] atan_type;

   localparam atan_type ATAN_TURNS [CORDIC_STEPS] = '{
      25'sd2097152, 25'sd1238021, 25'sd654136, 25'sd332050, 25'sd166669,
      25'sd83416, 25'sd41718, 25'sd20860, 25'sd10430, 25'sd5215,
      25'sd2608, 25'sd1304, 25'sd652, 25'sd326, 25'sd163,
      25'sd81, 25'sd41, 25'sd20, 25'sd10, 25'sd5
   };

   // integer square root, elaboration only
   function automatic logic [63:0] isqrt64(input logic [63:0] val);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] bitv;
      v = val;
      res = '0;
      bitv = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (bitv > v) bitv = bitv >> 2;
      end
      for (int i = 0; i < 32; i++) begin
         if (bitv != 0) begin
            if (v >= res + bitv) begin
               v = v - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
      end
      return res;
   endfunction

   // inverse frequency in turns, q0.32, from the q32 exponent
   function automatic logic [31:0] inv_freq(input logic [63:0] e);
      logic [4:0]  n;
      logic [31:0] f;
      logic [63:0] acc;
      logic [63:0] c;
      logic [63:0] prod;
      n = e[36:32];
      f = e[31:0];
      acc = 64'd1 << 31;
      c = isqrt64(64'd1 << 61);
      for (int k = 1; k <= 31; k++) begin
         if (f[32-k]) acc = (acc * c) >> 31;
         c = isqrt64(c << 31);
      end
      prod = (acc * INV_TWO_PI_Q32) >> (31 + n);
      return prod[31:0];
   endfunction

endpackage

[hw/rtl/rotary_position_embedding_pair.sv]
// throughput: one transaction per cycle while the output is not stalled, set by the one-step-per-stage cordic pipeline
// stages: table + input, phase multiply, 22 cordic stages, four products, round/saturate
// every stage has its own ready, so bubbles are squeezed out while the output waits
// reset: synchronous active-high reset clears all valid bits; no clearing pass
// depends on rpe_pkg, rpe_cordic and rotary_position_embedding_pair_macros.svh
`include "rotary_position_embedding_pair_macros.svh"

module rotary_position_embedding_pair #(
   parameter int unsigned HEAD_DIM      = 128,
   parameter int unsigned POSITION_BITS = 16,
   parameter int unsigned DATA_BITS     = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // x_first, x_second, pair_index, position, zero pad (lowest bit up)
   input  logic [((2*DATA_BITS + 6 + POSITION_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // y_first, y_second, zero pad (lowest bit up)
   output logic [((2*DATA_BITS + 7) / 8) * 8 - 1:0] rsp_tdata
);
   localparam int unsigned DW = DATA_BITS;
   localparam int unsigned PB = POSITION_BITS;
   localparam int unsigned OUT_W = ((2*DW + 7) / 8) * 8;
   localparam int unsigned HALF = HEAD_DIM / 2;
   localparam int unsigned CW = rpe_pkg::CS_W;
   localparam int unsigned PW = DW + CW;
   localparam int unsigned SW = PW + 1;

   // inverse frequency table indexed by the raw pair index, wrap folded in
   logic [31:0] inv_rom [64];
   for (genvar g = 0; g < 64; g++) begin : g_rom
      localparam logic [63:0] IDX = 64'(g % HALF);
      localparam logic [63:0] EXPO = (64'd2 * IDX * rpe_pkg::LOG2_TENK) / HEAD_DIM;
      assign inv_rom[g] = rpe_pkg::inv_freq(EXPO);
   end

   logic signed [DW-1:0] x1_in, x2_in;
   logic [5:0]           pidx_in;
   logic [PB-1:0]        pos_in;
   assign x1_in = req_tdata[DW-1:0];
   assign x2_in = req_tdata[2*DW-1:DW];
   assign pidx_in = req_tdata[2*DW+5:2*DW];
   assign pos_in = req_tdata[2*DW+6+PB-1:2*DW+6];

   logic                 s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff;
   logic                 rdy1, rdy2, rdy3, rdy4;
   logic                 cor_in_ready, cor_out_valid;
   logic signed [DW-1:0] a1_ff, b1_ff, a2_ff, b2_ff;
   logic [PB-1:0]        pos1_ff;
   logic [31:0]          inv1_ff;
   logic [15:0]          phase_ff;
   logic [PB+31:0]       phase_prod;
   logic signed [CW-1:0] cos_q, sin_q;
   logic signed [DW-1:0] ac_a, ac_b;
   logic signed [PW-1:0] pac_ff, pbs_ff, pbc_ff, pas_ff;
   logic signed [DW-1:0] y1_ff, y2_ff;
   logic signed [DW-1:0] y1_in, y2_in;

   // ready chain
   assign rdy4 = !s4_v_ff || rsp_tready;
   assign rdy3 = !s3_v_ff || rdy4;
   assign rdy2 = !s2_v_ff || cor_in_ready;
   assign rdy1 = !s1_v_ff || rdy2;
   assign req_tready = rdy1;

   // stage 1: capture transaction and look up inverse frequency
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (rdy1) begin
         s1_v_ff <= req_tvalid;
      end
      if (rdy1) begin
         a1_ff <= x1_in;
         b1_ff <= x2_in;
         pos1_ff <= pos_in;
         inv1_ff <= inv_rom[pidx_in];
      end
   end

   // stage 2: phase in q0.16 turns
   assign phase_prod = {32'd0, pos1_ff} * {{PB{1'b0}}, inv1_ff};
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (rdy2) begin
         s2_v_ff <= s1_v_ff;
      end
      if (rdy2) begin
         phase_ff <= phase_prod[31:16];
         a2_ff <= a1_ff;
         b2_ff <= b1_ff;
      end
   end

   // sine and cosine
   rpe_cordic #(.DW(DW)) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_v_ff),
      .in_ready  (cor_in_ready),
      .phase     (phase_ff),
      .a_in      (a2_ff),
      .b_in      (b2_ff),
      .out_valid (cor_out_valid),
      .out_ready (rdy3),
      .cos_q     (cos_q),
      .sin_q     (sin_q),
      .a_out     (ac_a),
      .b_out     (ac_b)
   );

   // stage 3: four products
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (rdy3) begin
         s3_v_ff <= cor_out_valid;
      end
      if (rdy3) begin
         pac_ff <= PW'(ac_a) * PW'(cos_q);
         pbs_ff <= PW'(ac_b) * PW'(sin_q);
         pbc_ff <= PW'(ac_b) * PW'(cos_q);
         pas_ff <= PW'(ac_a) * PW'(sin_q);
      end
   end

   // round half up by 2^16 and saturate
   function automatic logic signed [DW-1:0] round_sat(input logic signed [SW-1:0] acc);
      logic signed [SW-1:0] r;
      logic signed [SW-1:0] hi;
      logic signed [SW-1:0] lo;
      r = (acc + SW'(32768)) >>> 16;
      hi = SW'((64'd1 << (DW-1)) - 64'd1);
      lo = -hi - SW'(1);
      if (r > hi) r = hi;
      if (r < lo) r = lo;
      return r[DW-1:0];
   endfunction

   assign y1_in = round_sat(SW'(pac_ff) - SW'(pbs_ff));
   assign y2_in = round_sat(SW'(pbc_ff) + SW'(pas_ff));

   // stage 4: output register
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
      end else if (rdy4) begin
         s4_v_ff <= s3_v_ff;
      end
      if (rdy4) begin
         y1_ff <= y1_in;
         y2_ff <= y2_in;
      end
   end

   assign rsp_tvalid = s4_v_ff;
   assign rsp_tdata = OUT_W'({y2_ff, y1_ff});

   `RPE_ASSERT_NEXT(a_s1_hold, s1_v_ff && !rdy2, s1_v_ff && $stable(inv1_ff),
                    "inverse frequency lost under stall")
   `RPE_ASSERT_NOW(a_req_full, !req_tready, s1_v_ff && s2_v_ff && !cor_in_ready,
                   "input refused with room in pipeline")
   `RPE_ASSERT_NEXT(a_phase_hold, s2_v_ff && !cor_in_ready, s2_v_ff && $stable(phase_ff),
                    "phase changed while stalled")

endmodule

[hw/rtl/rpe_cordic.sv]
// pipelined rotation cordic, one step per stage, quadrant fold and rounding at the end
// depends on rpe_pkg and rotary_position_embedding_pair_macros.svh
`include "rotary_position_embedding_pair_macros.svh"

module rpe_cordic #(
   parameter int unsigned DW = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [15:0]                     phase,
   input  logic signed [DW-1:0]            a_in,
   input  logic signed [DW-1:0]            b_in,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic signed [rpe_pkg::CS_W-1:0] cos_q,
   output logic signed [rpe_pkg::CS_W-1:0] sin_q,
   output logic signed [DW-1:0]            a_out,
   output logic signed [DW-1:0]            b_out
);
   localparam int unsigned NS = rpe_pkg::CORDIC_STEPS;
   localparam int unsigned XW = rpe_pkg::XY_W;
   localparam int unsigned ZW = rpe_pkg::Z_W;
   localparam int unsigned CW = rpe_pkg::CS_W;

   // stage 0 is the load stage, stage k holds the value after k steps
   logic                 v_ff [NS+1];
   logic signed [XW-1:0] x_ff [NS+1];
   logic signed [XW-1:0] y_ff [NS+1];
   logic signed [ZW-1:0] z_ff [NS+1];
   logic [1:0]           q_ff [NS+1];
   logic signed [DW-1:0] a_ff [NS+1];
   logic signed [DW-1:0] b_ff [NS+1];
   logic                 rdy [NS+2];

   logic                 ov_ff;
   logic signed [CW-1:0] c_ff, s_ff;
   logic signed [DW-1:0] ao_ff, bo_ff;
   logic signed [XW-1:0] xr, yr;
   logic signed [CW-1:0] c_in, s_in;

   // per-stage ready: a stage loads when empty or when it drains
   always_comb begin
      rdy[NS+1] = !ov_ff || out_ready;
      for (int k = NS; k >= 0; k--) rdy[k] = !v_ff[k] || rdy[k+1];
   end
   assign in_ready = rdy[0];

   // load stage
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (rdy[0]) begin
         v_ff[0] <= in_valid;
      end
      if (rdy[0]) begin
         x_ff[0] <= rpe_pkg::CORDIC_GAIN;
         y_ff[0] <= '0;
         z_ff[0] <= ZW'({phase[13:0], 8'd0});
         q_ff[0] <= phase[15:14];
         a_ff[0] <= a_in;
         b_ff[0] <= b_in;
      end
   end

   // one micro-rotation per stage
   for (genvar k = 1; k <= NS; k++) begin : g_step
      logic signed [XW-1:0] dx, dy;
      assign dx = y_ff[k-1] >>> (k-1);
      assign dy = x_ff[k-1] >>> (k-1);
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            v_ff[k] <= v_ff[k-1];
         end
         if (rdy[k]) begin
            if (z_ff[k-1] >= 0) begin
               x_ff[k] <= x_ff[k-1] - dx;
               y_ff[k] <= y_ff[k-1] + dy;
               z_ff[k] <= z_ff[k-1] - rpe_pkg::ATAN_TURNS[k-1];
            end else begin
               x_ff[k] <= x_ff[k-1] + dx;
               y_ff[k] <= y_ff[k-1] - dy;
               z_ff[k] <= z_ff[k-1] + rpe_pkg::ATAN_TURNS[k-1];
            end
            q_ff[k] <= q_ff[k-1];
            a_ff[k] <= a_ff[k-1];
            b_ff[k] <= b_ff[k-1];
         end
      end
   end

   // round to q.16 and fold the quadrant
   assign xr = (x_ff[NS] + XW'(8192)) >>> 14;
   assign yr = (y_ff[NS] + XW'(8192)) >>> 14;
   always_comb begin
      case (q_ff[NS])
         2'd0: begin
            c_in = xr[CW-1:0];
            s_in = yr[CW-1:0];
         end
         2'd1: begin
            c_in = -yr[CW-1:0];
            s_in = xr[CW-1:0];
         end
         2'd2: begin
            c_in = -xr[CW-1:0];
            s_in = -yr[CW-1:0];
         end
         default: begin
            c_in = yr[CW-1:0];
            s_in = -xr[CW-1:0];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (rdy[NS+1]) begin
         ov_ff <= v_ff[NS];
      end
      if (rdy[NS+1]) begin
         c_ff <= c_in;
         s_ff <= s_in;
         ao_ff <= a_ff[NS];
         bo_ff <= b_ff[NS];
      end
   end

   assign out_valid = ov_ff;
   assign cos_q = c_ff;
   assign sin_q = s_ff;
   assign a_out = ao_ff;
   assign b_out = bo_ff;

   `RPE_ASSERT_NEXT(a_last_hold, v_ff[NS] && !rdy[NS], v_ff[NS] && $stable(x_ff[NS]),
                    "cordic last stage lost data under stall")
   `RPE_ASSERT_NOW(a_ready_chain, !in_ready, v_ff[0] && ov_ff && !out_ready,
                   "cordic refused a transaction with room")
   `RPE_ASSERT_NEXT(a_out_hold, ov_ff && !out_ready, ov_ff && $stable(c_ff) && $stable(s_ff),
                    "cordic result changed while held")

endmodule

[tb/tb_rotary_position_embedding_pair.sv]
// self-checking testbench for rotary_position_embedding_pair: directed table, then random pairs
// depends on rpe_pkg (cordic and frequency constants) and the rotary_position_embedding_pair rtl
module tb_rotary_position_embedding_pair;

   localparam int unsigned HEAD_DIM = 128;
   localparam int unsigned IN_W = 56;
   localparam int unsigned OUT_W = 32;
   localparam int unsigned STALL_LIMIT = 3000;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned DRAIN_CYCLES = 40;
   localparam int unsigned RANDOM_PER_PHASE = 240;

   typedef struct packed {
      logic [15:0]        position;
      logic [5:0]         pair_index;
      logic signed [15:0] x_second;
      logic signed [15:0] x_first;
   } pair_item_type;

   typedef struct packed {
      logic signed [15:0] y_second;
      logic signed [15:0] y_first;
   } rotated_type;

   // one row of the directed table; known marks an expectation read off directly
   typedef struct {
      pair_item_type item;
      bit            known;
      rotated_type   rotated;
   } vector_type;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [IN_W-1:0]  req_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [OUT_W-1:0] rsp_tdata;

   rotated_type      pending_rotations[$];
   longint unsigned  turns_per_step[64];
   int               errors;
   int               quiet_cycles;
   int               send_idle_pct;
   int               recv_idle_pct;
   bit               hold_request;
   bit               hold_taken;
   int               hold_count;

   rotary_position_embedding_pair #(
      .HEAD_DIM(HEAD_DIM),
      .POSITION_BITS(16),
      .DATA_BITS(16)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   // clock, period 10
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // bitwise integer square root
   function automatic longint unsigned int_sqrt(input longint unsigned val);
      longint unsigned v;
      longint unsigned root;
      longint unsigned probe;
      v = val;
      root = 0;
      probe = 64'd1 << 62;
      while (probe > v) probe = probe >> 2;
      while (probe != 0) begin
         if (v >= root + probe) begin
            v = v - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   // rotation per position step in turns, q0.32, for one pair index
   function automatic longint unsigned turns_for_index(input int idx);
      longint unsigned expo;
      longint unsigned frac;
      longint unsigned scale;
      longint unsigned factor;
      int              whole;
      expo = (2 * longint'(idx) * rpe_pkg::LOG2_TENK) / HEAD_DIM;
      whole = int'((expo >> 32) & 31);
      frac = expo & 64'hFFFF_FFFF;
      scale = 64'd1 << 31;
      factor = int_sqrt(64'd1 << 61);
      for (int k = 1; k <= 31; k++) begin
         if ((frac >> (32 - k)) & 1) scale = (scale * factor) >> 31;
         factor = int_sqrt(factor << 31);
      end
      return (scale * rpe_pkg::INV_TWO_PI_Q32) >> (31 + whole);
   endfunction

   // round half up by 2^16, clamp to 16-bit signed
   function automatic logic signed [15:0] round_clamp(input longint sum);
      longint r;
      r = (sum + 32768) >>> 16;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
   endfunction

   // rotate one pair by position times the per-index frequency
   function automatic rotated_type rotate_pair(input pair_item_type it);
      rotated_type     res;
      longint unsigned angle;
      longint          cx, cy, cz, dx, dy, cosv, sinv, cq, sq, a, b;
      int              quadrant;
      angle = ((longint'(it.position) * turns_per_step[it.pair_index % (HEAD_DIM / 2)]) >> 16)
              & 16'hFFFF;
      quadrant = int'(angle >> 14);
      cz = longint'(angle & 14'h3FFF) << 8;
      cx = longint'(rpe_pkg::CORDIC_GAIN);
      cy = 0;
      for (int k = 0; k < rpe_pkg::CORDIC_STEPS; k++) begin
         dx = cy >>> k;
         dy = cx >>> k;
         if (cz >= 0) begin
            cx = cx - dx; cy = cy + dy; cz = cz - longint'(rpe_pkg::ATAN_TURNS[k]);
         end else begin
            cx = cx + dx; cy = cy - dy; cz = cz + longint'(rpe_pkg::ATAN_TURNS[k]);
         end
      end
      cq = (cx + 8192) >>> 14;
      sq = (cy + 8192) >>> 14;
      // fold the first-quadrant result into the full circle
      case (quadrant)
         0: begin cosv = cq;  sinv = sq;  end
         1: begin cosv = -sq; sinv = cq;  end
         2: begin cosv = -cq; sinv = -sq; end
         default: begin cosv = sq; sinv = -cq; end
      endcase
      a = longint'(it.x_first);
      b = longint'(it.x_second);
      res.y_first = round_clamp(a * cosv - b * sinv);
      res.y_second = round_clamp(b * cosv + a * sinv);
      return res;
   endfunction

   function automatic pair_item_type make_item(input int xf, input int xs, input int idx,
                                               input int pos);
      pair_item_type it;
      it.x_first = xf[15:0];
      it.x_second = xs[15:0];
      it.pair_index = idx[5:0];
      it.position = pos[15:0];
      return it;
   endfunction

   // offer one transaction, wait for acceptance, queue its rotation
   task automatic send_pair(input pair_item_type it, input bit known, input rotated_type given);
      bit taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, it};
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
      pending_rotations.insert(pending_rotations.size(), known ? given : rotate_pair(it));
   endtask

   // random pair, biased toward extremes now and then
   function automatic pair_item_type random_item();
      pair_item_type it;
      logic [63:0]   raw;
      int            pick;
      raw = {$urandom, $urandom};
      it = raw[$bits(pair_item_type)-1:0];
      pick = $urandom_range(9);
      if (pick == 0) begin
         it.x_first = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
         it.x_second = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      end else if (pick == 1) begin
         it.position = $urandom_range(1) ? 16'hFFFF : 16'(int'($urandom_range(8)));
      end else if (pick == 2) begin
         it.pair_index = $urandom_range(1) ? 6'd63 : 6'd0;
      end
      return it;
   endfunction

   // receiver: random stall, or one long hold-off when requested
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_taken <= 1'b0;
         hold_count <= 0;
      end else if (hold_request && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_count <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_count > 0) begin
         hold_count <= hold_count - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // result check and watchdog, sampled mid-cycle where everything is settled
   always @(negedge clock) begin
      rotated_type got;
      rotated_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rotated_type'(rsp_tdata);
            if (pending_rotations.size() == 0) begin
               $display("%0t: unexpected transaction, expected none actual %h", $time,
                        rsp_tdata);
               errors++;
            end else begin
               want = pending_rotations.pop_front();
               if (got.y_first !== want.y_first) begin
                  $display("%0t: y_first mismatch, expected %0d actual %0d", $time,
                           want.y_first, got.y_first);
                  errors++;
               end
               if (got.y_second !== want.y_second) begin
                  $display("%0t: y_second mismatch, expected %0d actual %0d", $time,
                           want.y_second, got.y_second);
                  errors++;
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // stimulus
   initial begin
      vector_type  directed[$];
      vector_type  row;
      rotated_type zero_pair;
      errors = 0;
      quiet_cycles = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      for (int i = 0; i < 64; i++) turns_per_step[i] = turns_for_index(i);
      zero_pair = '0;

      // zero data rotates to zero at any angle
      row.known = 1'b1; row.rotated = zero_pair;
      row.item = make_item(0, 0, 0, 0);          directed.insert(directed.size(), row);
      row.item = make_item(0, 0, 63, 65535);     directed.insert(directed.size(), row);
      row.item = make_item(0, 0, 0, 65535);      directed.insert(directed.size(), row);
      row.item = make_item(0, 0, 31, 1234);      directed.insert(directed.size(), row);
      // remaining rows against the predictor
      row.known = 1'b0;
      row.item = make_item(4096, 0, 0, 0);       directed.insert(directed.size(), row);
      row.item = make_item(0, 4096, 0, 0);       directed.insert(directed.size(), row);
      row.item = make_item(32767, 32767, 0, 0);  directed.insert(directed.size(), row);
      row.item = make_item(-32768, -32768, 0, 0); directed.insert(directed.size(), row);
      // walk the quadrants at the fastest frequency
      for (int p = 1; p <= 7; p++) begin
         row.item = make_item(4096, -4096, 0, p); directed.insert(directed.size(), row);
      end
      // saturation at extreme data and angles
      row.item = make_item(32767, 32767, 0, 1);        directed.insert(directed.size(), row);
      row.item = make_item(-32768, 32767, 0, 2);       directed.insert(directed.size(), row);
      row.item = make_item(32767, -32768, 0, 3);       directed.insert(directed.size(), row);
      row.item = make_item(-32768, -32768, 0, 65535);  directed.insert(directed.size(), row);
      row.item = make_item(32767, -32768, 63, 65535);  directed.insert(directed.size(), row);
      row.item = make_item(-32768, 32767, 63, 0);      directed.insert(directed.size(), row);
      row.item = make_item(12345, -6789, 32, 40000);   directed.insert(directed.size(), row);

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_pair(directed[i].item, directed[i].known, directed[i].rotated);

      // random phases: no idling, sender idle, receiver stall, both light
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            1: begin send_idle_pct = 63; recv_idle_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_idle_pct = 63; end
            default: begin send_idle_pct = 6; recv_idle_pct = 6; end
         endcase
         repeat (RANDOM_PER_PHASE) send_pair(random_item(), 1'b0, zero_pair);
      end

      // back pressure: receiver holds off while the sender keeps offering
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request = 1'b1;
      repeat (80) send_pair(random_item(), 1'b0, zero_pair);
      req_tvalid <= 1'b0;

      // drain
      while (pending_rotations.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
